### src/msrcd_pkg.sv
`timescale 1ns / 1ps

package msrcd_pkg;

   // command codes
   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_READ    = 3'd2;
   localparam logic [2:0] CMD_SEARCH  = 3'd3;
   localparam logic [2:0] CMD_DEL_ROW = 3'd4;
   localparam logic [2:0] CMD_DEL_COL = 3'd5;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_DIM   = 3'd1;
   localparam logic [2:0] ST_BAD_POS   = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // most results one read-all or search may emit
   localparam int RESULT_CAP = 64;
   localparam int CNT_WIDTH  = 7;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [3:0]         row_arg;
      logic [3:0]         col_arg;
      logic signed [31:0] data_in;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         row_out;
      logic [2:0]         col_out;
      logic signed [31:0] data_out;
      logic               last;
   } rsp_type;

   // cell memory port controls
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

### src/msrcd_if.sv
`timescale 1ns / 1ps

// command channel
interface msrcd_req_if
   import msrcd_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// result channel
interface msrcd_rsp_if
   import msrcd_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/msrcd_cells.sv
`timescale 1ns / 1ps

// Cell store: one write port, one registered read port.
// A per-entry valid bit makes never-written cells read as zero after reset.
module msrcd_cells
   import msrcd_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = 6,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mem_ctl_type           ctl,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_vld_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // written-entry flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

### src/matrix_store_row_col_delete_top.sv
`timescale 1ns / 1ps

// Channel | Dir | Handshake     | Payload
// req_ch  | in  | valid / ready | cmd, row_arg, col_arg, data_in
// rsp_ch  | out | valid / ready | status, row_out, col_out, data_out, last
//
// Status-only commands (create, write, rejects, deletes that move no cell): the result is
// registered in the hold stage, then in the output register that drives rsp_ch.
// Read all / search walk one cell per cycle, up to the result cap, while rsp_ch does not
// stall them; delete row moves each later row up, delete column each later column left.
// Reset clears all written-cell flags. A stalled rsp_ch holds a read or search walk; a new
// item is taken once the walk is done and the hold stage has emptied to the output register.
module matrix_store_row_col_delete_top
   import msrcd_pkg::*;
#(
   parameter int ROW_MAX    = 8,
   parameter int COL_MAX    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   msrcd_req_if.sink   req_ch,
   msrcd_rsp_if.source rsp_ch
);

   localparam int CELLS = ROW_MAX * COL_MAX;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   // row-major address at a fixed stride of COL_MAX
   function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [4:0] c);
      logic [9:0] full;
      full = 10'(r) * 10'(COL_MAX) + 10'(c);
      return full[AW-1:0];
   endfunction

   // source cell of a walk step
   function automatic logic [AW-1:0] src_addr(input logic [2:0] mode,
                                              input logic [3:0] a, input logic [3:0] b);
      logic [4:0] a1;
      logic [AW-1:0] res;
      a1 = {1'b0, a} + 5'd1;
      case (mode)
         CMD_DEL_ROW: res = addr_of(a1, {1'b0, b});
         CMD_DEL_COL: res = addr_of({1'b0, b}, a1);
         default:     res = addr_of({1'b0, a}, {1'b0, b});
      endcase
      return res;
   endfunction

   // destination cell of a delete step
   function automatic logic [AW-1:0] dst_addr(input logic [2:0] mode,
                                              input logic [3:0] a, input logic [3:0] b);
      logic [AW-1:0] res;
      case (mode)
         CMD_DEL_COL: res = addr_of({1'b0, b}, {1'b0, a});
         default:     res = addr_of({1'b0, a}, {1'b0, b});
      endcase
      return res;
   endfunction

   state_type             state_ff, state_in;
   logic [2:0]            mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [3:0]            pos_a_ff, pos_a_in;
   logic [3:0]            pos_b_ff, pos_b_in;
   logic [3:0]            lim_a_ff, lim_a_in;
   logic [3:0]            lim_b_ff, lim_b_in;
   logic [CNT_WIDTH-1:0]  n_ff, n_in;
   logic [3:0]            row_cnt_ff, row_cnt_in;
   logic [3:0]            col_cnt_ff, col_cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         mem_rd_addr;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   req_type               req;
   logic                  req_ready;
   logic                  accept;
   logic                  out_free;
   logic [63:0]           key_ext;
   logic [63:0]           cell_ext;
   logic [4:0]            a_nxt, b_nxt;
   logic [3:0]            a_next, b_next;
   logic                  walk_end;
   logic                  hit, stall, fin, cand_take, push;
   logic                  create_bad, pos_bad, row_moves, col_moves;
   logic                  start_scan, start_move;

   msrcd_cells #(
      .DEPTH      (CELLS),
      .ADDR_WIDTH (AW),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_cells (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // handshake
   assign req        = req_ch.payload;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready  = (state_ff == S_IDLE) && !pend_valid_ff;
   assign accept     = req_ch.valid && req_ready;
   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // operand sizing
   assign key_ext  = 64'(req.data_in);
   assign cell_ext = 64'(mem_rd_data);

   // command decode
   assign create_bad = (req.row_arg == 4'd0) || ({1'b0, req.row_arg} > 5'(ROW_MAX)) ||
                       (req.col_arg == 4'd0) || ({1'b0, req.col_arg} > 5'(COL_MAX));
   always_comb begin
      case (req.cmd)
         CMD_WRITE:   pos_bad = (req.row_arg >= row_cnt_ff) || (req.col_arg >= col_cnt_ff);
         CMD_DEL_ROW: pos_bad = req.row_arg >= row_cnt_ff;
         CMD_DEL_COL: pos_bad = req.col_arg >= col_cnt_ff;
         default:     pos_bad = 1'b0;
      endcase
   end
   assign row_moves = ({1'b0, req.row_arg} + 5'd1 < {1'b0, row_cnt_ff}) &&
                      (col_cnt_ff != 4'd0);
   assign col_moves = ({1'b0, req.col_arg} + 5'd1 < {1'b0, col_cnt_ff}) &&
                      (row_cnt_ff != 4'd0);
   assign start_scan = accept && ((req.cmd == CMD_READ) || (req.cmd == CMD_SEARCH)) &&
                       (row_cnt_ff != 4'd0) && (col_cnt_ff != 4'd0);
   assign start_move = accept && !pos_bad &&
                       (((req.cmd == CMD_DEL_ROW) && row_moves) ||
                        ((req.cmd == CMD_DEL_COL) && col_moves));

   // walk position stepping: outer index a, inner index b
   assign a_nxt    = {1'b0, pos_a_ff} + 5'd1;
   assign b_nxt    = {1'b0, pos_b_ff} + 5'd1;
   assign walk_end = (b_nxt >= {1'b0, lim_b_ff}) && (a_nxt >= {1'b0, lim_a_ff});
   assign a_next   = (b_nxt >= {1'b0, lim_b_ff}) ? a_nxt[3:0] : pos_a_ff;
   assign b_next   = (b_nxt >= {1'b0, lim_b_ff}) ? 4'd0 : b_nxt[3:0];

   // scan evaluation of the cell just read
   assign hit       = (state_ff == S_SCAN) && ((mode_ff == CMD_READ) || (mem_rd_data == key_ff));
   assign stall     = hit && pend_valid_ff && !out_free;
   assign cand_take = hit && !stall;
   assign fin       = walk_end || (hit && (n_ff == CNT_WIDTH'(RESULT_CAP - 1)));

   // hold stage moves on when its item is known final or a newer match replaces it
   assign push = pend_valid_ff && out_free && (pend_ff.last || cand_take);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_scan) begin
               state_in = S_SCAN;
            end else if (start_move) begin
               state_in = S_MOVE;
            end
         end
         S_SCAN: begin
            if (!stall && fin) begin
               state_in = S_IDLE;
            end
         end
         S_MOVE: begin
            if (walk_end) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in       = mode_ff;
      key_in        = key_ff;
      pos_a_in      = pos_a_ff;
      pos_b_in      = pos_b_ff;
      lim_a_in      = lim_a_ff;
      lim_b_in      = lim_b_ff;
      n_in          = n_ff;
      row_cnt_in    = row_cnt_ff;
      col_cnt_in    = col_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_ctl       = '0;
      mem_rd_addr   = src_addr(mode_ff, a_next, b_next);
      mem_wr_addr   = dst_addr(mode_ff, pos_a_ff, pos_b_ff);
      mem_wr_data   = mem_rd_data;

      // output register
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         pend_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req.cmd;
               key_in  = key_ext[DATA_WIDTH-1:0];
               n_in    = '0;
               // status-only result by default; walks overwrite below
               pend_in.status   = ST_OK;
               pend_in.row_out  = 3'd0;
               pend_in.col_out  = 3'd0;
               pend_in.data_out = '0;
               pend_in.last     = 1'b1;
               case (req.cmd)
                  CMD_CREATE: begin
                     pend_valid_in = 1'b1;
                     if (create_bad) begin
                        pend_in.status = ST_BAD_DIM;
                        row_cnt_in     = 4'd0;
                        col_cnt_in     = 4'd0;
                     end else begin
                        row_cnt_in = req.row_arg;
                        col_cnt_in = req.col_arg;
                     end
                  end
                  CMD_WRITE: begin
                     pend_valid_in = 1'b1;
                     if (pos_bad) begin
                        pend_in.status = ST_BAD_POS;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = addr_of({1'b0, req.row_arg}, {1'b0, req.col_arg});
                        mem_wr_data   = key_ext[DATA_WIDTH-1:0];
                     end
                  end
                  CMD_READ, CMD_SEARCH: begin
                     if (start_scan) begin
                        pos_a_in      = 4'd0;
                        pos_b_in      = 4'd0;
                        lim_a_in      = row_cnt_ff;
                        lim_b_in      = col_cnt_ff;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = addr_of(5'd0, 5'd0);
                     end else begin
                        pend_valid_in  = 1'b1;
                        pend_in.status = (req.cmd == CMD_READ) ? ST_EMPTY : ST_NOT_FOUND;
                     end
                  end
                  CMD_DEL_ROW: begin
                     pend_valid_in = 1'b1;
                     if (pos_bad) begin
                        pend_in.status = ST_BAD_POS;
                     end else if (row_moves) begin
                        pos_a_in      = req.row_arg;
                        pos_b_in      = 4'd0;
                        lim_a_in      = row_cnt_ff - 4'd1;
                        lim_b_in      = col_cnt_ff;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = src_addr(CMD_DEL_ROW, req.row_arg, 4'd0);
                     end else begin
                        row_cnt_in = row_cnt_ff - 4'd1;
                     end
                  end
                  CMD_DEL_COL: begin
                     pend_valid_in = 1'b1;
                     if (pos_bad) begin
                        pend_in.status = ST_BAD_POS;
                     end else if (col_moves) begin
                        pos_a_in      = req.col_arg;
                        pos_b_in      = 4'd0;
                        lim_a_in      = col_cnt_ff - 4'd1;
                        lim_b_in      = row_cnt_ff;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = src_addr(CMD_DEL_COL, req.col_arg, 4'd0);
                     end else begin
                        col_cnt_in = col_cnt_ff - 4'd1;
                     end
                  end
                  default: begin
                     // unused codes: no result
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (!stall) begin
               if (hit) begin
                  pend_valid_in    = 1'b1;
                  pend_in.status   = ST_OK;
                  pend_in.row_out  = pos_a_ff[2:0];
                  pend_in.col_out  = pos_b_ff[2:0];
                  pend_in.data_out = cell_ext[31:0];
                  pend_in.last     = fin;
                  n_in             = n_ff + CNT_WIDTH'(1);
               end else if (fin) begin
                  if (pend_valid_ff) begin
                     pend_in.last = 1'b1;
                  end else begin
                     pend_valid_in    = 1'b1;
                     pend_in.status   = ST_NOT_FOUND;
                     pend_in.row_out  = 3'd0;
                     pend_in.col_out  = 3'd0;
                     pend_in.data_out = '0;
                     pend_in.last     = 1'b1;
                  end
               end
               if (!fin) begin
                  pos_a_in      = a_next;
                  pos_b_in      = b_next;
                  mem_ctl.rd_en = 1'b1;
               end
            end
         end

         S_MOVE: begin
            // write the cell read last cycle, read the next source
            mem_ctl.wr_en = 1'b1;
            if (walk_end) begin
               if (mode_ff == CMD_DEL_ROW) begin
                  row_cnt_in = row_cnt_ff - 4'd1;
               end else begin
                  col_cnt_in = col_cnt_ff - 4'd1;
               end
            end else begin
               pos_a_in      = a_next;
               pos_b_in      = b_next;
               mem_ctl.rd_en = 1'b1;
            end
         end

         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_cnt_ff    <= 4'd0;
         col_cnt_ff    <= 4'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         row_cnt_ff    <= row_cnt_in;
         col_cnt_ff    <= col_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         n_ff          <= n_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      pos_a_ff <= pos_a_in;
      pos_b_ff <= pos_b_in;
      lim_a_ff <= lim_a_in;
      lim_b_ff <= lim_b_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### src/msrcd_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the matrix store
module msrcd_checker
   import msrcd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_row,
   input logic [2:0]  rsp_col,
   input logic [31:0] rsp_data,
   input logic        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_row) &&
      $stable(rsp_col) && $stable(rsp_data) && $stable(rsp_last))
      else $error("result changed while stalled");

   // error and not-found results stand alone and carry no cell
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
      rsp_last && (rsp_row == 3'd0) && (rsp_col == 3'd0) && (rsp_data == 32'd0))
      else $error("status result with payload or without last");

   // no new command while a multi-result answer is still open
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command taken before last result");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_BAD_DIM) ||
      (rsp_status == ST_BAD_POS) || (rsp_status == ST_EMPTY) || (rsp_status == ST_NOT_FOUND))
      else $error("status out of range");

   // reset leaves no result and an open command port
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind matrix_store_row_col_delete_top msrcd_checker u_msrcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.payload.status),
   .rsp_row    (rsp_ch.payload.row_out),
   .rsp_col    (rsp_ch.payload.col_out),
   .rsp_data   (rsp_ch.payload.data_out),
   .rsp_last   (rsp_ch.payload.last)
);

### verif/msrcd_result_check.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the matrix and compares each
// result item against the oldest predicted one.
module msrcd_result_check
   import msrcd_pkg::*;
#(
   parameter int ROW_MAX = 8,
   parameter int COL_MAX = 8
) (
   input  logic  clock,
   input  logic  reset,
   msrcd_req_if  req_mon,
   msrcd_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    results_pending,
   output int    results_seen
);

   localparam int REPORT_LIMIT = 30;

   // shadow matrix, fixed row stride of COL_MAX
   logic signed [31:0] grid [ROW_MAX*COL_MAX];
   int                 rows_now;
   int                 cols_now;
   rsp_type            predicted_rsp_q [$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic push_status(input logic [2:0] st);
      rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      predicted_rsp_q.push_back(r);
   endtask

   task automatic push_cell(input int i, input int j);
      rsp_type r;
      r          = '0;
      r.status   = ST_OK;
      r.row_out  = 3'(i);
      r.col_out  = 3'(j);
      r.data_out = grid[i*COL_MAX + j];
      predicted_rsp_q.push_back(r);
   endtask

   // next state of the matrix and the results one command causes
   task automatic apply_matrix_cmd(input req_type it);
      int hits;
      hits = 0;
      case (it.cmd)
         CMD_CREATE: begin
            if (it.row_arg == 0 || it.row_arg > ROW_MAX ||
                it.col_arg == 0 || it.col_arg > COL_MAX) begin
               rows_now = 0;
               cols_now = 0;
               push_status(ST_BAD_DIM);
            end else begin
               rows_now = it.row_arg;
               cols_now = it.col_arg;
               push_status(ST_OK);
            end
         end
         CMD_WRITE: begin
            if (it.row_arg >= rows_now || it.col_arg >= cols_now) begin
               push_status(ST_BAD_POS);
            end else begin
               grid[it.row_arg*COL_MAX + it.col_arg] = it.data_in;
               push_status(ST_OK);
            end
         end
         CMD_READ: begin
            if (rows_now == 0 || cols_now == 0) begin
               push_status(ST_EMPTY);
            end else begin
               for (int i = 0; i < rows_now; i++) begin
                  for (int j = 0; j < cols_now; j++) begin
                     if (hits < RESULT_CAP) begin
                        push_cell(i, j);
                        hits++;
                     end
                  end
               end
               predicted_rsp_q[predicted_rsp_q.size()-1].last = 1'b1;
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < rows_now; i++) begin
               for (int j = 0; j < cols_now; j++) begin
                  if (hits < RESULT_CAP && grid[i*COL_MAX + j] == it.data_in) begin
                     push_cell(i, j);
                     hits++;
                  end
               end
            end
            if (hits == 0) begin
               push_status(ST_NOT_FOUND);
            end else begin
               predicted_rsp_q[predicted_rsp_q.size()-1].last = 1'b1;
            end
         end
         CMD_DEL_ROW: begin
            if (it.row_arg >= rows_now) begin
               push_status(ST_BAD_POS);
            end else begin
               for (int i = it.row_arg; i + 1 < rows_now; i++) begin
                  for (int j = 0; j < cols_now; j++) begin
                     grid[i*COL_MAX + j] = grid[(i+1)*COL_MAX + j];
                  end
               end
               rows_now--;
               push_status(ST_OK);
            end
         end
         CMD_DEL_COL: begin
            if (it.col_arg >= cols_now) begin
               push_status(ST_BAD_POS);
            end else begin
               for (int j = it.col_arg; j + 1 < cols_now; j++) begin
                  for (int i = 0; i < rows_now; i++) begin
                     grid[i*COL_MAX + j] = grid[i*COL_MAX + j + 1];
                  end
               end
               cols_now--;
               push_status(ST_OK);
            end
         end
         default: ;  // spare codes are dropped silently
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_seen++;
      if (predicted_rsp_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result status %0d row %0d col %0d data %0h",
                                   got.status, got.row_out, got.col_out, got.data_out));
         return;
      end
      want = predicted_rsp_q.pop_front();
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.row_out !== want.row_out)
         report_mismatch($sformatf("row_out %0d, expected %0d", got.row_out, want.row_out));
      if (got.col_out !== want.col_out)
         report_mismatch($sformatf("col_out %0d, expected %0d", got.col_out, want.col_out));
      if (got.data_out !== want.data_out)
         report_mismatch($sformatf("data_out %0h, expected %0h", got.data_out, want.data_out));
      if (got.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
   endtask

   // results are checked before the new command is predicted
   always @(posedge clock) begin
      if (reset) begin
         foreach (grid[n]) grid[n] = '0;
         rows_now = 0;
         cols_now = 0;
         predicted_rsp_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result(rsp_mon.payload);
         if (req_mon.valid && req_mon.ready) apply_matrix_cmd(req_mon.payload);
      end
      results_pending <= predicted_rsp_q.size();
   end

endmodule

### verif/matrix_store_row_col_delete_top_tb.sv
`timescale 1ns / 1ps

module matrix_store_row_col_delete_top_tb;
   import msrcd_pkg::*;

   // codes the block must ignore
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam int RANDOM_ITEMS = 250;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   logic clock;
   logic reset;

   msrcd_req_if req_ch ();
   msrcd_rsp_if rsp_ch ();

   int mismatch_count;
   int results_pending;
   int results_seen;
   int cycle_count;
   int cmd_tally [8];
   int burst_left;
   bit bulk_phase;
   int shape_rows = 1;
   int shape_cols = 1;

   logic [31:0] value_pool [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h5a5a_5a5a, 32'h0000_0007};

   matrix_store_row_col_delete_top #(
      .ROW_MAX    (8),
      .COL_MAX    (8),
      .DATA_WIDTH (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   msrcd_result_check #(
      .ROW_MAX (8),
      .COL_MAX (8)
   ) result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_seen    (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type pack_cmd(input logic [2:0] c, input logic [3:0] r,
                                        input logic [3:0] k, input logic [31:0] d);
      req_type it;
      it.cmd     = c;
      it.row_arg = r;
      it.col_arg = k;
      it.data_in = d;
      return it;
   endfunction

   function automatic logic [31:0] pick_data();
      if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   // mostly well-formed commands sized to the last good create, some noise
   function automatic req_type random_cmd();
      int          pick;
      logic [3:0]  r;
      logic [3:0]  k;
      pick = $urandom_range(0, 99);
      r    = 4'($urandom_range(0, shape_rows - 1));
      k    = 4'($urandom_range(0, shape_cols - 1));
      if (pick < 6)
         return pack_cmd(CMD_CREATE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         $urandom);
      if (pick < 16)
         return pack_cmd(CMD_CREATE,
                         ($urandom_range(0, 4) == 0) ? 4'd8 : 4'($urandom_range(1, 4)),
                         ($urandom_range(0, 4) == 0) ? 4'd8 : 4'($urandom_range(1, 4)),
                         $urandom);
      if (pick < 46) return pack_cmd(CMD_WRITE, r, k, pick_data());
      if (pick < 56) return pack_cmd(CMD_READ, r, k, $urandom);
      if (pick < 72) return pack_cmd(CMD_SEARCH, r, k, pick_data());
      if (pick < 80) return pack_cmd(CMD_DEL_ROW, r, k, $urandom);
      if (pick < 88) return pack_cmd(CMD_DEL_COL, r, k, $urandom);
      return pack_cmd(3'($urandom_range(CMD_CREATE, CMD_DEL_COL)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
   endfunction

   // one item per call; gaps fall between bursts
   task automatic send_item(input req_type it);
      int gap;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      cmd_tally[it.cmd]++;
      if (it.cmd == CMD_CREATE && it.row_arg inside {[1:8]} && it.col_arg inside {[1:8]}) begin
         shape_rows = it.row_arg;
         shape_cols = it.col_arg;
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // command stimulus
   initial begin
      req_type script [$];
      int      sent;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty matrix, bad dimensions, full 8x8, deletes, cells kept over create
      script.push_back(pack_cmd(CMD_READ, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_SEARCH, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_WRITE, 4'd0, 4'd0, 32'h1));
      script.push_back(pack_cmd(CMD_DEL_ROW, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_DEL_COL, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd0, 4'd3, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd9, 4'd8, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd8, 4'd9, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd8, 4'd8, 32'h0));
      script.push_back(pack_cmd(CMD_WRITE, 4'd7, 4'd7, 32'h7fff_ffff));
      script.push_back(pack_cmd(CMD_WRITE, 4'd0, 4'd0, 32'h8000_0000));
      script.push_back(pack_cmd(CMD_WRITE, 4'd3, 4'd5, 32'hffff_ffff));
      script.push_back(pack_cmd(CMD_WRITE, 4'd7, 4'd8, 32'h1234));
      script.push_back(pack_cmd(CMD_READ, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_SEARCH, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_SEARCH, 4'd0, 4'd0, 32'h8000_0000));
      script.push_back(pack_cmd(CMD_SPARE_A, 4'd15, 4'd15, 32'hffff_ffff));
      script.push_back(pack_cmd(CMD_DEL_ROW, 4'd7, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_DEL_ROW, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_DEL_COL, 4'd0, 4'd3, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd2, 4'd2, 32'h0));
      script.push_back(pack_cmd(CMD_READ, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_CREATE, 4'd1, 4'd1, 32'h0));
      script.push_back(pack_cmd(CMD_DEL_ROW, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_READ, 4'd0, 4'd0, 32'h0));
      script.push_back(pack_cmd(CMD_SEARCH, 4'd0, 4'd0, 32'hffff_ffff));
      foreach (script[n]) send_item(script[n]);
      wait_drained();

      // random traffic; one full drain halfway through
      bulk_phase = 1'b1;
      sent       = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 29) == 0)
            send_item(pack_cmd(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B,
                               4'($urandom), 4'($urandom), $urandom));
         send_item(random_cmd());
         sent++;
         if (sent == RANDOM_ITEMS / 2) wait_drained();
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d create, %0d write, %0d read-all, %0d search, %0d row delete,",
               cmd_tally[CMD_CREATE], cmd_tally[CMD_WRITE], cmd_tally[CMD_READ],
               cmd_tally[CMD_SEARCH], cmd_tally[CMD_DEL_ROW]);
      $display("%0d column delete and %0d spare-code commands; %0d result items compared.",
               cmd_tally[CMD_DEL_COL], cmd_tally[CMD_SPARE_A] + cmd_tally[CMD_SPARE_B],
               results_seen);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // result backpressure: varying patterns, one long hold once traffic is random
   initial begin
      int mode;
      int span;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (bulk_phase && !held) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         for (int k = 0; k < span; k++) begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= (k % 3 != 0);
            endcase
            @(posedge clock);
         end
      end
   end

endmodule
